// File: rtl/core/sec_pkg.sv
// shared types, constants and helpers of the serial expression calculator
package sec_pkg;

	localparam int WORD_W  = 16;
	localparam int BYTE_W  = 8;
	localparam int RES_W   = 16;
	localparam int MAG_W   = 14;
	localparam int CNT_W   = $clog2(WORD_W + 1);

	localparam logic [MAG_W-1:0]  MAG_LIMIT = MAG_W'(9999);
	localparam logic [BYTE_W-1:0] CH_CR     = BYTE_W'(13);
	localparam logic [BYTE_W-1:0] CH_ZERO   = BYTE_W'(48);
	localparam logic [BYTE_W-1:0] CH_NINE   = BYTE_W'(57);
	localparam logic [BYTE_W-1:0] CH_PLUS   = BYTE_W'(43);
	localparam logic [BYTE_W-1:0] CH_MINUS  = BYTE_W'(45);
	localparam logic [BYTE_W-1:0] CH_STAR   = BYTE_W'(42);
	localparam logic [BYTE_W-1:0] CH_SLASH  = BYTE_W'(47);

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_OTHER
	} op_t;

	typedef struct packed {
		logic              start;
		op_t               op;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] result;
	} alu_rsp_t;

	typedef struct packed {
		logic              valid;
		logic              err;
		logic [WORD_W-1:0] word;
	} sat_req_t;

	typedef struct packed {
		logic             done;
		logic [RES_W-1:0] result;
		logic [MAG_W-1:0] mag;
		logic             neg;
		logic             ovf;
		logic             err;
	} sat_rsp_t;

	function automatic logic [WORD_W-1:0] abs_word(input logic [WORD_W-1:0] v);
		return v[WORD_W-1] ? (~v + WORD_W'(1)) : v;
	endfunction

	function automatic op_t decode_op(input logic [BYTE_W-1:0] b);
		op_t op;
		case (b)
			CH_PLUS:  op = OP_ADD;
			CH_MINUS: op = OP_SUB;
			CH_STAR:  op = OP_MUL;
			CH_SLASH: op = OP_DIV;
			default:  op = OP_OTHER;
		endcase
		return op;
	endfunction

endpackage

// File: rtl/core/sec_in_if.sv
// input byte channel of the serial expression calculator
interface sec_in_if;
	logic                        valid;
	logic                        ready;
	logic [sec_pkg::BYTE_W-1:0]  rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// File: rtl/core/sec_out_if.sv
// result channel of the serial expression calculator
interface sec_out_if;
	logic                              valid;
	logic                              ready;
	logic [sec_pkg::BYTE_W-1:0]        echo_byte;
	logic                              newline_first;
	logic                              expr_done;
	logic signed [sec_pkg::RES_W-1:0]  signed_result;
	logic [sec_pkg::MAG_W-1:0]         display_magnitude;
	logic                              minus_flag;
	logic                              overflow_flag;
	logic                              error_flag;

	modport source (output valid, output echo_byte, output newline_first, output expr_done,
		output signed_result, output display_magnitude, output minus_flag,
		output overflow_flag, output error_flag, input ready);
	modport sink (input valid, input echo_byte, input newline_first, input expr_done,
		input signed_result, input display_magnitude, input minus_flag,
		input overflow_flag, input error_flag, output ready);
endinterface

// File: rtl/core/sec_alu.sv
// arithmetic unit: registered add and subtract, bit-serial multiply and restoring divide
module sec_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  sec_pkg::alu_req_t req,
	output sec_pkg::alu_rsp_t rsp
);
	import sec_pkg::*;

	logic              busy_q;
	logic              done_q;
	op_t               op_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W-1:0] acc_q;
	logic [WORD_W-1:0] x_q;
	logic [WORD_W-1:0] y_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] res_q;
	logic              neg_q;

	logic [WORD_W-1:0] acc_sum;
	logic [WORD_W:0]   rem_shift;
	logic [WORD_W:0]   rem_diff;
	logic              rem_ge;
	logic [WORD_W-1:0] quot_next;

	// multiply: add the multiplicand when the low multiplier bit is set
	assign acc_sum   = acc_q + (y_q[0] ? x_q : '0);
	// divide: quotient bits shift into x_q as dividend bits leave it
	assign rem_shift = {rem_q, x_q[WORD_W-1]};
	assign rem_diff  = rem_shift - {1'b0, y_q};
	assign rem_ge    = !rem_diff[WORD_W];
	assign quot_next = {x_q[WORD_W-2:0], rem_ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_ADD;
			cnt_q  <= '0;
			acc_q  <= '0;
			x_q    <= '0;
			y_q    <= '0;
			rem_q  <= '0;
			res_q  <= '0;
			neg_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				op_q <= req.op;
				case (req.op)
					OP_ADD: begin
						res_q  <= req.a + req.b;
						done_q <= 1'b1;
					end
					OP_SUB: begin
						res_q  <= req.a - req.b;
						done_q <= 1'b1;
					end
					OP_MUL: begin
						acc_q  <= '0;
						x_q    <= req.a;
						y_q    <= req.b;
						cnt_q  <= CNT_W'(WORD_W);
						busy_q <= 1'b1;
					end
					OP_DIV: begin
						x_q    <= abs_word(req.a);
						y_q    <= abs_word(req.b);
						rem_q  <= '0;
						neg_q  <= req.a[WORD_W-1] ^ req.b[WORD_W-1];
						cnt_q  <= CNT_W'(WORD_W);
						busy_q <= 1'b1;
					end
					default: begin
						res_q  <= '0;
						done_q <= 1'b1;
					end
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (op_q == OP_MUL) begin
					acc_q <= acc_sum;
					x_q   <= {x_q[WORD_W-2:0], 1'b0};
					y_q   <= {1'b0, y_q[WORD_W-1:1]};
				end else begin
					rem_q <= rem_ge ? rem_diff[WORD_W-1:0] : rem_shift[WORD_W-1:0];
					x_q   <= quot_next;
				end
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					if (op_q == OP_MUL) begin
						res_q <= acc_sum;
					end else begin
						res_q <= neg_q ? (~quot_next + WORD_W'(1)) : quot_next;
					end
				end
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = res_q;

endmodule

// File: rtl/core/sec_sat.sv
// result store: magnitude, saturation to the display limit and status flags
module sec_sat (
	input  logic              clk,
	input  logic              arst_n,
	input  sec_pkg::sat_req_t req,
	output sec_pkg::sat_rsp_t rsp
);
	import sec_pkg::*;

	logic              done_q;
	logic [RES_W-1:0]  result_q;
	logic [MAG_W-1:0]  mag_q;
	logic              neg_q;
	logic              ovf_q;
	logic              err_q;

	logic [WORD_W-1:0] mag_full;
	logic              too_big;

	assign mag_full = abs_word(req.word);
	// most negative word has no positive twin and lands here as well
	assign too_big  = mag_full > WORD_W'(MAG_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= 1'b0;
			result_q <= '0;
			mag_q    <= '0;
			neg_q    <= 1'b0;
			ovf_q    <= 1'b0;
			err_q    <= 1'b0;
		end else begin
			done_q <= req.valid;
			if (req.valid) begin
				if (req.err) begin
					result_q <= '0;
					mag_q    <= '0;
					neg_q    <= 1'b0;
					ovf_q    <= 1'b0;
					err_q    <= 1'b1;
				end else begin
					result_q <= req.word[RES_W-1:0];
					mag_q    <= too_big ? MAG_LIMIT : mag_full[MAG_W-1:0];
					neg_q    <= req.word[WORD_W-1];
					ovf_q    <= too_big;
					err_q    <= 1'b0;
				end
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = result_q;
	assign rsp.mag    = mag_q;
	assign rsp.neg    = neg_q;
	assign rsp.ovf    = ovf_q;
	assign rsp.err    = err_q;

endmodule

// File: rtl/core/serial_expression_calculator.sv
// top level: byte parser, operand accumulation and result channel
// path: a byte that does not evaluate goes from idle to the emit state, then into the free output register
// path: carriage return with add, subtract or other operator: calc, sat, emit; division by zero skips calc
// path: multiply and divide wait in calc for the one-bit-per-cycle arithmetic unit
// throughput: one byte at a time; a new byte is taken while the previous beat waits
// reset: operands, operator and last result clear to zero, no beat pending
module serial_expression_calculator (
	input  logic      clk,
	input  logic      arst_n,
	sec_in_if.sink    rx,
	sec_out_if.source tx
);
	import sec_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_SAT,
		ST_EMIT
	} state_t;

	state_t            state_q;
	logic              phase_q;
	logic [WORD_W-1:0] left_q;
	logic [WORD_W-1:0] right_q;
	op_t               op_q;
	logic [BYTE_W-1:0] byte_q;
	logic              done_q;

	logic              tx_valid_q;
	logic [BYTE_W-1:0] tx_byte_q;
	logic              tx_done_q;
	logic [RES_W-1:0]  tx_result_q;
	logic [MAG_W-1:0]  tx_mag_q;
	logic              tx_neg_q;
	logic              tx_ovf_q;
	logic              tx_err_q;

	logic              accept;
	logic              is_digit;
	logic              is_cr;
	logic [3:0]        digit_val;
	op_t               eff_op;
	logic              div_zero;

	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;
	sat_req_t          sat_req;
	sat_rsp_t          sat_rsp;

	function automatic logic [WORD_W-1:0] times_ten_plus(input logic [WORD_W-1:0] v,
		input logic [3:0] d);
		return {v[WORD_W-4:0], 3'b000} + {v[WORD_W-2:0], 1'b0} + WORD_W'(d);
	endfunction

	assign accept    = rx.valid && rx.ready;
	assign is_digit  = (rx.rx_byte >= CH_ZERO) && (rx.rx_byte <= CH_NINE);
	assign is_cr     = rx.rx_byte == CH_CR;
	// ascii digits sit at 0x30..0x39, so the low nibble is the value
	assign digit_val = rx.rx_byte[3:0];
	// in the first phase a carriage return is also the operator byte
	assign eff_op    = phase_q ? op_q : decode_op(rx.rx_byte);
	assign div_zero  = (eff_op == OP_DIV) && (right_q == '0);

	assign alu_req.start = accept && is_cr && !div_zero;
	assign alu_req.op    = eff_op;
	assign alu_req.a     = left_q;
	assign alu_req.b     = right_q;

	assign sat_req.valid = (accept && is_cr && div_zero) || (state_q == ST_CALC && alu_rsp.done);
	assign sat_req.err   = state_q == ST_IDLE;
	assign sat_req.word  = alu_rsp.result;

	sec_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	sec_sat u_sat (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sat_req),
		.rsp    (sat_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= 1'b0;
			left_q      <= '0;
			right_q     <= '0;
			op_q        <= OP_ADD;
			byte_q      <= '0;
			done_q      <= 1'b0;
			tx_valid_q  <= 1'b0;
			tx_byte_q   <= '0;
			tx_done_q   <= 1'b0;
			tx_result_q <= '0;
			tx_mag_q    <= '0;
			tx_neg_q    <= 1'b0;
			tx_ovf_q    <= 1'b0;
			tx_err_q    <= 1'b0;
		end else begin
			// the emit state refills the output register itself
			if (tx_valid_q && tx.ready && state_q != ST_EMIT) begin
				tx_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						byte_q <= rx.rx_byte;
						done_q <= is_cr;
						if (!phase_q && !is_digit) begin
							op_q <= eff_op;
						end
						if (!phase_q && is_digit) begin
							left_q  <= times_ten_plus(left_q, digit_val);
							state_q <= ST_EMIT;
						end else if (is_digit) begin
							right_q <= times_ten_plus(right_q, digit_val);
							state_q <= ST_EMIT;
						end else if (is_cr) begin
							phase_q <= 1'b0;
							left_q  <= '0;
							right_q <= '0;
							state_q <= div_zero ? ST_SAT : ST_CALC;
						end else begin
							phase_q <= 1'b1;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_CALC: begin
					if (alu_rsp.done) begin
						state_q <= ST_SAT;
					end
				end
				ST_SAT: begin
					if (sat_rsp.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// output register free or being emptied this cycle
					if (!tx_valid_q || tx.ready) begin
						tx_valid_q  <= 1'b1;
						tx_byte_q   <= byte_q;
						tx_done_q   <= done_q;
						tx_result_q <= sat_rsp.result;
						tx_mag_q    <= sat_rsp.mag;
						tx_neg_q    <= sat_rsp.neg;
						tx_ovf_q    <= sat_rsp.ovf;
						tx_err_q    <= sat_rsp.err;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rx.ready             = state_q == ST_IDLE;
	assign tx.valid             = tx_valid_q;
	assign tx.echo_byte         = tx_byte_q;
	assign tx.newline_first     = tx_byte_q == CH_CR;
	assign tx.expr_done         = tx_done_q;
	assign tx.signed_result     = tx_result_q;
	assign tx.display_magnitude = tx_mag_q;
	assign tx.minus_flag        = tx_neg_q;
	assign tx.overflow_flag     = tx_ovf_q;
	assign tx.error_flag        = tx_err_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("byte taken but parser stayed idle");

	a_alu_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> state_q == ST_CALC)
		else $error("arithmetic unit finished outside of calculation");

	a_sat_done_in_sat: assert property (@(posedge clk) disable iff (!arst_n)
		sat_rsp.done |-> state_q == ST_SAT)
		else $error("result store updated outside of its wait state");

	a_done_is_cr: assert property (@(posedge clk) disable iff (!arst_n)
		(tx.valid && tx.expr_done) |-> tx.newline_first)
		else $error("evaluation beat without carriage return");

	a_err_clears_mag: assert property (@(posedge clk) disable iff (!arst_n)
		(tx.valid && tx.error_flag) |-> (tx.display_magnitude == '0 && !tx.minus_flag))
		else $error("division by zero left a nonzero magnitude");

endmodule

// File: sim/sec_result_check.sv
`timescale 1ns / 1ps
// scoreboard for the calculator: predicts every result beat and compares it
module sec_result_check (
	input  logic clk,
	input  logic arst_n,
	sec_in_if    rx,
	sec_out_if   tx,
	output int   errors,
	output int   pending
);
	import sec_pkg::*;

	typedef struct packed {
		logic [BYTE_W-1:0]       echo;
		logic                    nl;
		logic                    done;
		logic signed [RES_W-1:0] result;
		logic [MAG_W-1:0]        mag;
		logic                    neg;
		logic                    ovf;
		logic                    err;
	} beat_t;

	logic              on_rhs;
	logic [WORD_W-1:0] lhs;
	logic [WORD_W-1:0] rhs;
	op_t               opc;
	logic [WORD_W-1:0] res;
	logic [MAG_W-1:0]  mag;
	logic              neg;
	logic              sat;
	logic              dz;
	beat_t             calc_due[$];
	int                fail_count = 0;
	int                beat_count = 0;

	assign errors  = fail_count;
	assign pending = calc_due.size();

	task automatic calc_byte(input logic [BYTE_W-1:0] b, output beat_t e);
		logic                    digit;
		logic                    done;
		logic [WORD_W-1:0]       d;
		logic signed [WORD_W:0]  sa;
		logic signed [WORD_W:0]  sb;
		logic signed [WORD_W:0]  sr;
		logic signed [WORD_W:0]  am;
		digit = (b >= CH_ZERO) && (b <= CH_NINE);
		done  = 1'b0;
		d     = WORD_W'(b - CH_ZERO);
		if (!on_rhs) begin
			if (digit) begin
				lhs = lhs * WORD_W'(10) + d;
			end else begin
				case (b)
					CH_PLUS:  opc = OP_ADD;
					CH_MINUS: opc = OP_SUB;
					CH_STAR:  opc = OP_MUL;
					CH_SLASH: opc = OP_DIV;
					default:  opc = OP_OTHER;
				endcase
				on_rhs = 1'b1;
			end
		end
		// the operator byte falls through, so a bare carriage return evaluates here
		if (on_rhs) begin
			if (digit) begin
				rhs = rhs * WORD_W'(10) + d;
			end else if (b == CH_CR) begin
				done = 1'b1;
				neg  = 1'b0;
				sat  = 1'b0;
				dz   = 1'b0;
				if (opc == OP_DIV && rhs == '0) begin
					res = '0;
					mag = '0;
					dz  = 1'b1;
				end else begin
					// one extra bit keeps the most negative quotient exact before wrapping
					sa = $signed({lhs[WORD_W-1], lhs});
					sb = $signed({rhs[WORD_W-1], rhs});
					case (opc)
						OP_ADD:  sr = sa + sb;
						OP_SUB:  sr = sa - sb;
						OP_MUL:  sr = sa * sb;
						OP_DIV:  sr = sa / sb;
						default: sr = '0;
					endcase
					res = sr[WORD_W-1:0];
					neg = res[WORD_W-1];
					am  = $signed({res[WORD_W-1], res});
					if (am < 0)
						am = -am;
					if (am > 9999) begin
						mag = MAG_LIMIT;
						sat = 1'b1;
					end else begin
						mag = am[MAG_W-1:0];
					end
				end
				on_rhs = 1'b0;
				lhs    = '0;
				rhs    = '0;
			end
		end
		e.echo   = b;
		e.nl     = (b == CH_CR);
		e.done   = done;
		e.result = res[RES_W-1:0];
		e.mag    = mag;
		e.neg    = neg;
		e.ovf    = sat;
		e.err    = dz;
	endtask

	task automatic report(input string what, input beat_t e, input beat_t g);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%t: %s at result beat %0d", $realtime, what, beat_count);
			$display("  expected echo=%0d nl=%b done=%b result=%0d mag=%0d neg=%b ovf=%b err=%b",
				e.echo, e.nl, e.done, e.result, e.mag, e.neg, e.ovf, e.err);
			$display("  actual   echo=%0d nl=%b done=%b result=%0d mag=%0d neg=%b ovf=%b err=%b",
				g.echo, g.nl, g.done, g.result, g.mag, g.neg, g.ovf, g.err);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		beat_t e;
		beat_t g;
		if (!arst_n) begin
			on_rhs = 1'b0;
			lhs    = '0;
			rhs    = '0;
			opc    = OP_ADD;
			res    = '0;
			mag    = '0;
			neg    = 1'b0;
			sat    = 1'b0;
			dz     = 1'b0;
			calc_due.delete();
		end else begin
			if (tx.valid && tx.ready) begin
				g.echo   = tx.echo_byte;
				g.nl     = tx.newline_first;
				g.done   = tx.expr_done;
				g.result = tx.signed_result;
				g.mag    = tx.display_magnitude;
				g.neg    = tx.minus_flag;
				g.ovf    = tx.overflow_flag;
				g.err    = tx.error_flag;
				if (calc_due.size() == 0) begin
					report("unexpected beat", '0, g);
				end else begin
					e = calc_due.pop_front();
					if (g !== e)
						report("mismatch", e, g);
				end
				beat_count++;
			end
			if (rx.valid && rx.ready) begin
				calc_byte(rx.rx_byte, e);
				calc_due.push_back(e);
			end
		end
	end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// testbench top: clock, reset, byte stimulus, result backpressure and verdict
module tb;
	import sec_pkg::*;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   burst_left = 0;
	int   bytes_sent = 0;
	int   ignored_sent = 0;

	sec_in_if  rx_ch ();
	sec_out_if tx_ch ();

	serial_expression_calculator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.tx     (tx_ch)
	);

	sec_result_check scb (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_ch),
		.tx      (tx_ch),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				@(negedge clk);
				rx_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	function automatic int unsigned pick_operand();
		case ($urandom_range(0, 7))
			0, 1:    return $urandom_range(0, 99);
			2, 3:    return $urandom_range(0, 9999);
			4:       return $urandom_range(0, 65535);
			5:       return $urandom_range(65536, 99999);
			6:       return $urandom_range(0, 1) ? 32768 : 65535;
			default: return $urandom_range(0, 9);
		endcase
	endfunction

	// any non-digit, carriage return included
	function automatic logic [BYTE_W-1:0] pick_non_digit();
		logic [BYTE_W-1:0] b;
		do b = BYTE_W'($urandom_range(0, 255));
		while (b >= CH_ZERO && b <= CH_NINE);
		return b;
	endfunction

	// a byte the second operand ignores
	function automatic logic [BYTE_W-1:0] pick_inert();
		logic [BYTE_W-1:0] b;
		do b = BYTE_W'($urandom_range(0, 255));
		while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_CR);
		return b;
	endfunction

	task automatic send_expr();
		int sel;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom_range(0, 255)));
			return;
		end
		if ($urandom_range(0, 7) != 0)
			send_text($sformatf("%0d", pick_operand()));
		sel = $urandom_range(0, 9);
		case (sel)
			0, 1:    send_byte(CH_PLUS);
			2, 3:    send_byte(CH_MINUS);
			4, 5:    send_byte(CH_STAR);
			6, 7:    send_byte(CH_SLASH);
			8:       send_byte(pick_non_digit());
			default: ; // the carriage return itself then picks the operator
		endcase
		if (sel <= 7 && $urandom_range(0, 5) == 0) begin
			send_byte(pick_inert());
			ignored_sent++;
		end
		if ($urandom_range(0, 7) != 0) begin
			if ((sel == 6 || sel == 7) && $urandom_range(0, 3) == 0)
				send_text("0");
			else
				send_text($sformatf("%0d", pick_operand()));
		end
		send_byte(CH_CR);
	endtask

	// receiver: changing stall patterns plus two long hold-offs
	initial begin
		int cyc;
		int mode;
		int span;
		int k;
		tx_ch.ready = 1'b0;
		cyc  = 0;
		mode = 0;
		span = 0;
		k    = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc == 2000 || cyc == 12000) begin
				tx_ch.ready <= 1'b0;
				repeat (400) @(negedge clk);
			end else begin
				if (span == 0) begin
					mode = $urandom_range(0, 3);
					span = $urandom_range(50, 300);
				end
				span--;
				k++;
				case (mode)
					0:       tx_ch.ready <= 1'b1;
					1:       tx_ch.ready <= 1'($urandom_range(0, 1));
					2:       tx_ch.ready <= (k % 4 == 0);
					default: tx_ch.ready <= (k % 16 < 11);
				endcase
			end
		end
	end

	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// extreme bytes: zero becomes the operator, all-ones is ignored
		send_byte(8'h00);
		send_byte(8'hFF);
		ignored_sent++;
		send_byte(CH_CR);
		// division by zero
		send_text("7/0");
		send_byte(CH_CR);
		// most negative value divided by minus one
		send_text("32768/65535");
		send_byte(CH_CR);
		// empty first operand with subtraction gives a negative result
		send_text("-5");
		send_byte(CH_CR);

		while (bytes_sent - ignored_sent < 1400)
			send_expr();

		@(negedge clk);
		rx_ch.valid <= 1'b0;
		wait (pending == 0);
		repeat (40) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
